// ===== hw/rtl/pcc_pkg.sv =====
package pcc_pkg;

	localparam int ATOM_W  = 10;
	localparam int KIND_W  = 3;
	localparam int POS_W   = 24;
	localparam int DIST_W  = 52;
	localparam int COORD_W = 16;
	localparam int PAIR_W  = 32;
	localparam int CFG_IDX_W = 1;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_PAIR = 1'b1
	} req_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CUTOFF_SQ   = 1'b0,
		CFG_MIN_DIST_SQ = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		req_kind_t                req_type;
		logic [ATOM_W-1:0]        atom_a;
		logic [ATOM_W-1:0]        atom_b;
		logic [KIND_W-1:0]        atom_kind;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic signed [POS_W-1:0]  shift_x;
		logic signed [POS_W-1:0]  shift_y;
		logic signed [POS_W-1:0]  shift_z;
	} req_t;

	typedef struct packed {
		logic                bonded;
		logic [DIST_W-1:0]   distance_sq;
		logic [COORD_W-1:0]  count_a_of_b_kind;
		logic [COORD_W-1:0]  count_b_of_a_kind;
		logic [PAIR_W-1:0]   kind_pair_count;
		logic [PAIR_W-1:0]   bond_total_out;
	} res_t;

	typedef struct packed {
		cfg_idx_t            index;
		logic [DIST_W-1:0]   value;
	} cfg_t;

endpackage

// ===== hw/rtl/pcc_if.sv =====
interface pcc_req_if;
	logic          valid;
	logic          ready;
	pcc_pkg::req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pcc_res_if;
	logic          valid;
	logic          ready;
	pcc_pkg::res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pcc_cfg_if;
	logic          valid;
	logic          ready;
	pcc_pkg::cfg_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/pair_coordination_counter.sv =====
// pair coordination counter
// channels: req (load atom or test pair), res (one result per request),
// cfg (register writes: cutoff_sq, min_dist_sq), all valid/ready; a transfer
// happens on a rising edge with valid and ready both high. cfg is always ready.
// a load writes the atom's position, species and a zeroed counter row in the
// transfer cycle; its result is registered on leaving the done state.
// a pair reads atom a, then atom b from the single read port of the atom
// memory, forms the differences, squares, sums and compares, then, if bonded,
// writes back the counter rows of a and b one after the other; its result is
// registered on leaving the done state. a request with an atom index out of
// range behaves like a load in timing and changes nothing.
// a new request is taken only once the current one is through, set by the
// read-modify-write sequence on the one-read one-write atom memory.
// req is ready whenever no request is in progress, also while a result waits;
// a result that is not taken holds the next one back in its last step.
// reset clears the control and cfg registers, the bond total and the
// species-pair table (valid bits); atom memory is not cleared, no pass needed.
module pair_coordination_counter #(
	parameter int MAX_ATOMS = 1024,
	parameter int NUM_KINDS = 8,
	parameter int POS_BITS  = 24
) (
	input logic       clk,
	input logic       arst_n,
	pcc_req_if.sink   req,
	pcc_res_if.source res,
	pcc_cfg_if.sink   cfg
);

	localparam int AW       = $clog2(MAX_ATOMS);
	localparam int KW       = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
	localparam int DW       = POS_BITS + 2;
	localparam int SQW      = 2 * DW;
	localparam int PTAW     = 2 * KW;
	localparam int PT_DEPTH = 1 << PTAW;
	localparam int CW       = pcc_pkg::COORD_W;
	localparam int CW1      = CW + 1;
	localparam int PW       = pcc_pkg::PAIR_W;
	localparam int DSW      = pcc_pkg::DIST_W;

	typedef struct packed {
		logic [NUM_KINDS-1:0][CW-1:0] coord;
		logic [KW-1:0]                kind;
		logic [POS_BITS-1:0]          pz;
		logic [POS_BITS-1:0]          py;
		logic [POS_BITS-1:0]          px;
	} atom_word_t;

	localparam int AWW = $bits(atom_word_t);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_RD_B = 8'b0000_0010,
		ST_DIFF = 8'b0000_0100,
		ST_MUL  = 8'b0000_1000,
		ST_SUM  = 8'b0001_0000,
		ST_WB_A = 8'b0010_0000,
		ST_WB_B = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t                 state_q;
	logic                   in_xfer;
	logic                   a_ok;
	logic                   b_ok;
	logic                   res_free;
	logic                   is_pair_q;
	pcc_pkg::req_t          req_q;
	pcc_pkg::res_t          res_q;
	pcc_pkg::res_t          res_d;
	logic                   res_valid_q;
	logic [DSW-1:0]         cutoff_q;
	logic [DSW-1:0]         min_q;
	logic [PW-1:0]          total_q;
	logic [PT_DEPTH-1:0]    pt_valid_q;

	logic                   atom_we;
	logic [AW-1:0]          atom_waddr;
	atom_word_t             atom_wdata;
	logic [AW-1:0]          atom_raddr;
	atom_word_t             atom_rdata;
	atom_word_t             load_word;
	atom_word_t             upd_a;
	atom_word_t             upd_b;

	logic                   pt_we;
	logic [PTAW-1:0]        pt_raddr;
	logic [PW-1:0]          pt_rdata;
	logic [PTAW-1:0]        pt_addr_q;
	logic                   pt_hit_q;

	atom_word_t             row_a_q;
	atom_word_t             row_b_q;
	logic [KW-1:0]          ka_q;
	logic [KW-1:0]          kb_q;
	logic [KW-1:0]          lo_w;
	logic [KW-1:0]          hi_w;
	logic signed [DW-1:0]   dx_w;
	logic signed [DW-1:0]   dy_w;
	logic signed [DW-1:0]   dz_w;
	logic signed [DW-1:0]   dx_q;
	logic signed [DW-1:0]   dy_q;
	logic signed [DW-1:0]   dz_q;
	logic [SQW-1:0]         sqx_q;
	logic [SQW-1:0]         sqy_q;
	logic [SQW-1:0]         sqz_q;
	logic [SQW-1:0]         d2_w;
	logic [DSW-1:0]         d2_ext;
	logic                   bond_w;
	logic [SQW-1:0]         d2_q;
	logic                   bond_q;
	logic [PW-1:0]          pair_cnt_q;

	logic                   same_w;
	logic [CW-1:0]          cur_a;
	logic [CW-1:0]          cur_b;
	logic [CW1-1:0]         sum_a;
	logic [CW1-1:0]         sum_b;
	logic [CW-1:0]          new_a;
	logic [CW-1:0]          new_b;
	logic [PW-1:0]          pair_new;
	logic [PW-1:0]          total_new;
	logic [CW-1:0]          cnt_a_q;
	logic [CW-1:0]          cnt_b_q;
	logic [PW-1:0]          pair_q;

	assign req.ready = (state_q == ST_IDLE);
	assign in_xfer   = req.valid && req.ready;
	assign a_ok      = 32'(req.data.atom_a) < 32'(MAX_ATOMS);
	assign b_ok      = 32'(req.data.atom_b) < 32'(MAX_ATOMS);
	assign res_free  = !res_valid_q || res.ready;
	assign cfg.ready = 1'b1;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// new atom entry, counters cleared
	always_comb begin
		load_word    = '0;
		load_word.px = req.data.pos_x[POS_BITS-1:0];
		load_word.py = req.data.pos_y[POS_BITS-1:0];
		load_word.pz = req.data.pos_z[POS_BITS-1:0];
		load_word.kind = (32'(req.data.atom_kind) >= 32'(NUM_KINDS)) ?
			KW'(NUM_KINDS - 1) : KW'(req.data.atom_kind);
	end

	// differences, atom b arriving from memory
	always_comb begin
		dx_w = DW'($signed(atom_rdata.px)) - DW'($signed(row_a_q.px))
			+ DW'($signed(req_q.shift_x[POS_BITS-1:0]));
		dy_w = DW'($signed(atom_rdata.py)) - DW'($signed(row_a_q.py))
			+ DW'($signed(req_q.shift_y[POS_BITS-1:0]));
		dz_w = DW'($signed(atom_rdata.pz)) - DW'($signed(row_a_q.pz))
			+ DW'($signed(req_q.shift_z[POS_BITS-1:0]));
		lo_w = (row_a_q.kind < atom_rdata.kind) ? row_a_q.kind : atom_rdata.kind;
		hi_w = (row_a_q.kind < atom_rdata.kind) ? atom_rdata.kind : row_a_q.kind;
		pt_raddr = {lo_w, hi_w};
	end

	assign d2_w   = sqx_q + sqy_q + sqz_q;
	assign d2_ext = DSW'(d2_w);
	assign bond_w = (d2_ext <= cutoff_q) && (d2_ext > min_q);

	// saturating counter updates
	always_comb begin
		same_w    = (req_q.atom_a == req_q.atom_b);
		cur_a     = row_a_q.coord[kb_q];
		cur_b     = row_b_q.coord[ka_q];
		sum_a     = CW1'(cur_a) + (same_w ? CW1'(2) : CW1'(1));
		sum_b     = CW1'(cur_b) + CW1'(1);
		new_a     = sum_a[CW] ? '1 : sum_a[CW-1:0];
		new_b     = same_w ? new_a : (sum_b[CW] ? '1 : sum_b[CW-1:0]);
		pair_new  = (pair_cnt_q == '1) ? pair_cnt_q : pair_cnt_q + PW'(1);
		total_new = (total_q == '1) ? total_q : total_q + PW'(1);
		upd_a     = row_a_q;
		upd_a.coord[kb_q] = new_a;
		upd_b     = row_b_q;
		upd_b.coord[ka_q] = cnt_b_q;
	end

	// result word
	always_comb begin
		res_d                = '0;
		res_d.bond_total_out = total_q;
		if (is_pair_q) begin
			res_d.bonded            = bond_q;
			res_d.distance_sq       = DSW'(d2_q);
			res_d.count_a_of_b_kind = cnt_a_q;
			res_d.count_b_of_a_kind = cnt_b_q;
			res_d.kind_pair_count   = pair_q;
		end
	end

	always_comb begin
		atom_we    = 1'b0;
		atom_waddr = AW'(req.data.atom_a);
		atom_wdata = load_word;
		atom_raddr = AW'(req_q.atom_a);
		pt_we      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				atom_we    = in_xfer && (req.data.req_type == pcc_pkg::REQ_LOAD) && a_ok;
				atom_raddr = AW'(req.data.atom_a);
			end
			ST_RD_B: begin
				atom_raddr = AW'(req_q.atom_b);
			end
			ST_WB_A: begin
				atom_we    = bond_q;
				atom_waddr = AW'(req_q.atom_a);
				atom_wdata = upd_a;
				pt_we      = bond_q;
			end
			ST_WB_B: begin
				atom_we    = bond_q && !same_w;
				atom_waddr = AW'(req_q.atom_b);
				atom_wdata = upd_b;
			end
			default: ;
		endcase
	end

	pcc_ram #(
		.WIDTH(AWW),
		.DEPTH(MAX_ATOMS)
	) u_atom_ram (
		.clk  (clk),
		.we   (atom_we),
		.waddr(atom_waddr),
		.wdata(atom_wdata),
		.raddr(atom_raddr),
		.rdata(atom_rdata)
	);

	pcc_ram #(
		.WIDTH(PW),
		.DEPTH(PT_DEPTH)
	) u_pair_ram (
		.clk  (clk),
		.we   (pt_we),
		.waddr(pt_addr_q),
		.wdata(pair_new),
		.raddr(pt_raddr),
		.rdata(pt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			is_pair_q   <= 1'b0;
			res_valid_q <= 1'b0;
			cutoff_q    <= '0;
			min_q       <= '0;
			total_q     <= '0;
			pt_valid_q  <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.data.index)
					pcc_pkg::CFG_CUTOFF_SQ:   cutoff_q <= cfg.data.value;
					pcc_pkg::CFG_MIN_DIST_SQ: min_q    <= cfg.data.value;
					default: ;
				endcase
			end
			if ((state_q == ST_DONE) && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if ((req.data.req_type == pcc_pkg::REQ_PAIR) && a_ok && b_ok) begin
							is_pair_q <= 1'b1;
							state_q   <= ST_RD_B;
						end else begin
							is_pair_q <= 1'b0;
							state_q   <= ST_DONE;
						end
					end
				end
				ST_RD_B: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_WB_A;
				ST_WB_A: begin
					if (bond_q) begin
						total_q               <= total_new;
						pt_valid_q[pt_addr_q] <= 1'b1;
					end
					state_q <= ST_WB_B;
				end
				ST_WB_B: state_q <= ST_DONE;
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q <= req.data;
		end
		if (state_q == ST_RD_B) begin
			row_a_q <= atom_rdata;
		end
		if (state_q == ST_DIFF) begin
			row_b_q   <= atom_rdata;
			dx_q      <= dx_w;
			dy_q      <= dy_w;
			dz_q      <= dz_w;
			ka_q      <= row_a_q.kind;
			kb_q      <= atom_rdata.kind;
			pt_addr_q <= pt_raddr;
			pt_hit_q  <= pt_valid_q[pt_raddr];
		end
		if (state_q == ST_MUL) begin
			sqx_q      <= SQW'(dx_q * dx_q);
			sqy_q      <= SQW'(dy_q * dy_q);
			sqz_q      <= SQW'(dz_q * dz_q);
			pair_cnt_q <= pt_hit_q ? pt_rdata : '0;
		end
		if (state_q == ST_SUM) begin
			d2_q   <= d2_w;
			bond_q <= bond_w;
		end
		if (state_q == ST_WB_A) begin
			cnt_a_q <= bond_q ? new_a : cur_a;
			cnt_b_q <= bond_q ? new_b : cur_b;
			pair_q  <= bond_q ? pair_new : pair_cnt_q;
		end
		if ((state_q == ST_DONE) && res_free) begin
			res_q <= res_d;
		end
	end

	a_mem_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		atom_we |-> (state_q == ST_IDLE || state_q == ST_WB_A || state_q == ST_WB_B))
		else $error("atom memory written outside load or write-back");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB_A && bond_q && total_q != '1) |=>
		(total_q == $past(total_q) + PW'(1)))
		else $error("bond total not advanced on bond");

	a_bond_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.bonded) |->
		(res.data.bond_total_out != '0 && res.data.count_a_of_b_kind != '0 &&
		res.data.count_b_of_a_kind != '0 && res.data.kind_pair_count != '0))
		else $error("bond reported with a zero counter");

endmodule

// ===== hw/rtl/pcc_ram.sv =====
module pcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
